// ===== rtl/hsf_pkg.sv =====
`timescale 1ns / 1ps
package hsf_pkg;

    // a set needs this many points before a triangle is formed
    localparam int MIN_POINTS = 4;
    // axis extremes: xmin, xmax, ymin, ymax, zmin, zmax
    localparam int NUM_EXT = 6;
    // unordered pairs of extremes
    localparam int NUM_PAIRS = 15;

    // outcome codes
    localparam logic [1:0] OUTCOME_OK       = 2'd0;
    localparam logic [1:0] OUTCOME_FEW      = 2'd1;
    localparam logic [1:0] OUTCOME_OVERFLOW = 2'd2;

    // status that travels with one finished set
    typedef struct packed {
        logic bank;
        logic few;
        logic ovf;
    } job_ctl_t;

endpackage

// ===== rtl/hsf_point_if.sv =====
`timescale 1ns / 1ps
interface hsf_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               final_point;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output final_point, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input final_point, output ready);
endinterface

// ===== rtl/hsf_tri_if.sv =====
`timescale 1ns / 1ps
interface hsf_tri_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] apex_x;
    logic signed [31:0] apex_y;
    logic signed [31:0] apex_z;
    logic [1:0]         outcome;

    modport source (output valid, output first_x, output first_y, output first_z,
                    output second_x, output second_y, output second_z,
                    output apex_x, output apex_y, output apex_z,
                    output outcome, input ready);
    modport sink (input valid, input first_x, input first_y, input first_z,
                  input second_x, input second_y, input second_z,
                  input apex_x, input apex_y, input apex_z,
                  input outcome, output ready);
endinterface

// ===== rtl/hsf_ram.sv =====
`timescale 1ns / 1ps
module hsf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/hsf_job_fifo.sv =====
`timescale 1ns / 1ps
module hsf_job_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             valid,
    input  logic             pop,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             do_push;
    logic             do_pop;

    assign valid   = (cnt_reg != 2'd0);
    assign dout    = entry_reg[rp_reg];
    assign do_push = push && (cnt_reg != 2'd2);
    assign do_pop  = pop && valid;

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wp_reg] <= din;
        end
    end

endmodule

// ===== rtl/hsf_front.sv =====
`timescale 1ns / 1ps
module hsf_front #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    hsf_point_if.sink                                   points,
    input  logic                                        room,
    output logic                                        wr_en,
    output logic [$clog2(MAX_POINTS):0]                 wr_addr,
    output logic [3*COORD_BITS-1:0]                     wr_data,
    output logic                                        job_push,
    output hsf_pkg::job_ctl_t                           job_ctl,
    output logic [$clog2(MAX_POINTS+1)-1:0]             job_count,
    output logic [hsf_pkg::NUM_EXT*3*COORD_BITS-1:0]    job_ext
);

    localparam int CW   = COORD_BITS;
    localparam int PW   = 3 * CW;
    localparam int IDXW = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);

    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            ovf_reg;
    logic            bank_reg;
    logic [PW-1:0]   ext_reg  [hsf_pkg::NUM_EXT];
    logic [PW-1:0]   ext_upd  [hsf_pkg::NUM_EXT];
    logic [PW-1:0]   ext_init [hsf_pkg::NUM_EXT];
    logic [PW-1:0]   pt;
    logic            accept;
    logic            store;

    assign points.ready = room;
    assign accept       = points.valid && room;
    assign pt           = {points.pos_z[CW-1:0], points.pos_y[CW-1:0], points.pos_x[CW-1:0]};
    assign store        = (count_reg < CNTW'(MAX_POINTS));
    assign count_next   = store ? count_reg + 1'b1 : count_reg;

    // extreme tracking, strictly beyond only
    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            ext_init[2*ax]                 = '0;
            ext_init[2*ax][ax*CW +: CW]    = {1'b0, {(CW-1){1'b1}}};
            ext_init[2*ax+1]               = '0;
            ext_init[2*ax+1][ax*CW +: CW]  = {1'b1, {(CW-1){1'b0}}};
            if (store && ($signed(pt[ax*CW +: CW]) < $signed(ext_reg[2*ax][ax*CW +: CW])))
            begin
                ext_upd[2*ax] = pt;
            end
            else
            begin
                ext_upd[2*ax] = ext_reg[2*ax];
            end
            if (store && ($signed(pt[ax*CW +: CW]) > $signed(ext_reg[2*ax+1][ax*CW +: CW])))
            begin
                ext_upd[2*ax+1] = pt;
            end
            else
            begin
                ext_upd[2*ax+1] = ext_reg[2*ax+1];
            end
        end
    end

    // set state, back to empty after the last point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
            for (int e = 0; e < hsf_pkg::NUM_EXT; e++)
            begin
                ext_reg[e] <= ext_init[e];
            end
        end
        else if (accept)
        begin
            if (points.final_point)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
                bank_reg  <= ~bank_reg;
                for (int e = 0; e < hsf_pkg::NUM_EXT; e++)
                begin
                    ext_reg[e] <= ext_init[e];
                end
            end
            else
            begin
                count_reg <= count_next;
                ovf_reg   <= ovf_reg | ~store;
                for (int e = 0; e < hsf_pkg::NUM_EXT; e++)
                begin
                    ext_reg[e] <= ext_upd[e];
                end
            end
        end
    end

    // point store write
    assign wr_en   = accept && store;
    assign wr_addr = {bank_reg, count_reg[IDXW-1:0]};
    assign wr_data = pt;

    // finished set goes to the queue
    assign job_push     = accept && points.final_point;
    assign job_ctl.bank = bank_reg;
    assign job_ctl.ovf  = ovf_reg | ~store;
    assign job_ctl.few  = (count_next < CNTW'(hsf_pkg::MIN_POINTS));
    assign job_count    = count_next;

    always_comb
    begin
        for (int e = 0; e < hsf_pkg::NUM_EXT; e++)
        begin
            job_ext[e*PW +: PW] = ext_upd[e];
        end
    end

endmodule

// ===== rtl/hsf_back.sv =====
`timescale 1ns / 1ps
module hsf_back #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        job_valid,
    input  hsf_pkg::job_ctl_t                           job_ctl,
    input  logic [$clog2(MAX_POINTS+1)-1:0]             job_count,
    input  logic [hsf_pkg::NUM_EXT*3*COORD_BITS-1:0]    job_ext,
    output logic                                        job_pop,
    output logic                                        rd_en,
    output logic [$clog2(MAX_POINTS):0]                 rd_addr,
    input  logic [3*COORD_BITS-1:0]                     rd_data,
    output logic                                        release_job,
    hsf_tri_if.source                                   corners
);

    localparam int CW   = COORD_BITS;
    localparam int D    = CW + 1;
    localparam int PW   = 3 * CW;
    localparam int IDXW = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int PSW  = 2 * D + 2;
    localparam int SQW  = 4 * D;
    localparam int SSW  = 4 * D + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAIR  = 3'd1;
    localparam logic [2:0] S_ABSEL = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    hsf_pkg::job_ctl_t                ctl_reg;
    logic [CNTW-1:0]                  cnt_reg;
    logic [hsf_pkg::NUM_EXT*PW-1:0]   ext_reg;
    logic [PW-1:0]                    ext_pt [hsf_pkg::NUM_EXT];
    logic [3:0]                       pk_reg;
    logic [3:0]                       sel;
    logic [PW-1:0]                    ea;
    logic [PW-1:0]                    eb;
    logic                             p_issue;
    logic                             s_issue;
    logic [CNTW-1:0]                  sn_reg;

    // pair pipeline
    logic [2:0]                       pv_reg;
    logic [2:0]                       plast_reg;
    logic [3:0]                       pidx_reg [3];
    logic [D-1:0]                     pmag_reg [3];
    logic [2*D-1:0]                   psq_reg  [3];
    logic [PSW-1:0]                   psum_reg;
    logic [PSW-1:0]                   pbest_d_reg;
    logic [3:0]                       pbest_reg;
    logic                             phave_reg;
    logic                             p_better;

    // scan pipeline
    logic [6:0]                       sv_reg;
    logic [6:0]                       slast_reg;
    logic [PW-1:0]                    a_pt_reg;
    logic [PW-1:0]                    b_pt_reg;
    logic [PW-1:0]                    q_reg [6];
    logic signed [D-1:0]              da_reg [3];
    logic signed [D-1:0]              db_reg [3];
    logic signed [2*D-1:0]            m_reg [6];
    logic [2*D-1:0]                   cmag_reg [3];
    logic [2*D-1:0]                   hh_reg [3];
    logic [2*D-1:0]                   hl_reg [3];
    logic [2*D-1:0]                   ll_reg [3];
    logic [SQW-1:0]                   sq_reg [3];
    logic [SSW-1:0]                   sum_reg;
    logic [SSW-1:0]                   cbest_d_reg;
    logic [PW-1:0]                    c_pt_reg;
    logic                             chave_reg;
    logic                             s_better;

    // result register
    logic [PW-1:0]                    res_first_reg;
    logic [PW-1:0]                    res_second_reg;
    logic [PW-1:0]                    res_apex_reg;
    logic [1:0]                       res_outcome_reg;

    always_comb
    begin
        for (int e = 0; e < hsf_pkg::NUM_EXT; e++)
        begin
            ext_pt[e] = ext_reg[e*PW +: PW];
        end
    end

    // pair code to the two extremes, in test order
    assign sel = (state_reg == S_ABSEL) ? pbest_reg : pk_reg;

    always_comb
    begin
        case (sel)
            4'd0:    begin ea = ext_pt[0]; eb = ext_pt[1]; end
            4'd1:    begin ea = ext_pt[0]; eb = ext_pt[2]; end
            4'd2:    begin ea = ext_pt[0]; eb = ext_pt[3]; end
            4'd3:    begin ea = ext_pt[0]; eb = ext_pt[4]; end
            4'd4:    begin ea = ext_pt[0]; eb = ext_pt[5]; end
            4'd5:    begin ea = ext_pt[1]; eb = ext_pt[2]; end
            4'd6:    begin ea = ext_pt[1]; eb = ext_pt[3]; end
            4'd7:    begin ea = ext_pt[1]; eb = ext_pt[4]; end
            4'd8:    begin ea = ext_pt[1]; eb = ext_pt[5]; end
            4'd9:    begin ea = ext_pt[2]; eb = ext_pt[3]; end
            4'd10:   begin ea = ext_pt[2]; eb = ext_pt[4]; end
            4'd11:   begin ea = ext_pt[2]; eb = ext_pt[5]; end
            4'd12:   begin ea = ext_pt[3]; eb = ext_pt[4]; end
            4'd13:   begin ea = ext_pt[3]; eb = ext_pt[5]; end
            4'd14:   begin ea = ext_pt[4]; eb = ext_pt[5]; end
            default: begin ea = ext_pt[0]; eb = ext_pt[1]; end
        endcase
    end

    assign p_issue  = (state_reg == S_PAIR) && (pk_reg < 4'(hsf_pkg::NUM_PAIRS));
    assign s_issue  = (state_reg == S_SCAN) && (sn_reg < cnt_reg);
    assign p_better = !phave_reg || (psum_reg > pbest_d_reg);
    assign s_better = !chave_reg || (sum_reg > cbest_d_reg);

    assign rd_en   = s_issue;
    assign rd_addr = {ctl_reg.bank, sn_reg[IDXW-1:0]};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job_ctl.few ? S_OUT : S_PAIR;
                end
            end
            S_PAIR:
            begin
                if (pv_reg[2] && plast_reg[2])
                begin
                    state_next = S_ABSEL;
                end
            end
            S_ABSEL:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (sv_reg[6] && slast_reg[6])
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (corners.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign job_pop     = (state_reg == S_IDLE) && job_valid;
    assign release_job = (state_reg == S_OUT) && corners.ready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pk_reg    <= '0;
            sn_reg    <= '0;
            pv_reg    <= '0;
            sv_reg    <= '0;
            phave_reg <= 1'b0;
            chave_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= {pv_reg[1:0], p_issue};
            sv_reg    <= {sv_reg[5:0], s_issue};
            if (job_pop)
            begin
                pk_reg    <= '0;
                phave_reg <= 1'b0;
            end
            else if (p_issue)
            begin
                pk_reg <= pk_reg + 4'd1;
            end
            if (pv_reg[2] && p_better)
            begin
                phave_reg <= 1'b1;
            end
            if (state_reg == S_ABSEL)
            begin
                sn_reg    <= '0;
                chave_reg <= 1'b0;
            end
            else
            begin
                if (s_issue)
                begin
                    sn_reg <= sn_reg + 1'b1;
                end
                if (sv_reg[6] && s_better)
                begin
                    chave_reg <= 1'b1;
                end
            end
        end
    end

    // job capture and pair datapath
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            ctl_reg <= job_ctl;
            cnt_reg <= job_count;
            ext_reg <= job_ext;
        end
        plast_reg <= {plast_reg[1:0], (pk_reg == 4'(hsf_pkg::NUM_PAIRS - 1))};
        pidx_reg[0] <= pk_reg;
        pidx_reg[1] <= pidx_reg[0];
        pidx_reg[2] <= pidx_reg[1];
        // stage 1: per-axis distance magnitude
        for (int k = 0; k < 3; k++)
        begin
            if ($signed(ea[k*CW +: CW]) < $signed(eb[k*CW +: CW]))
            begin
                pmag_reg[k] <= D'($signed(eb[k*CW +: CW])) - D'($signed(ea[k*CW +: CW]));
            end
            else
            begin
                pmag_reg[k] <= D'($signed(ea[k*CW +: CW])) - D'($signed(eb[k*CW +: CW]));
            end
        end
        // stage 2: squares
        for (int k = 0; k < 3; k++)
        begin
            psq_reg[k] <= (2*D)'(pmag_reg[k]) * (2*D)'(pmag_reg[k]);
        end
        // stage 3: sum
        psum_reg <= PSW'(psq_reg[0]) + PSW'(psq_reg[1]) + PSW'(psq_reg[2]);
        // stage 4: keep the first strictly longest pair
        if (pv_reg[2] && p_better)
        begin
            pbest_d_reg <= psum_reg;
            pbest_reg   <= pidx_reg[2];
        end
        if (state_reg == S_ABSEL)
        begin
            a_pt_reg <= ea;
            b_pt_reg <= eb;
        end
    end

    // scan datapath
    always_ff @(posedge clk)
    begin
        slast_reg <= {slast_reg[5:0], (sn_reg == cnt_reg - 1'b1)};
        // stage 1: offsets from both line ends
        q_reg[0] <= rd_data;
        for (int k = 0; k < 3; k++)
        begin
            da_reg[k] <= D'($signed(rd_data[k*CW +: CW])) - D'($signed(a_pt_reg[k*CW +: CW]));
            db_reg[k] <= D'($signed(rd_data[k*CW +: CW])) - D'($signed(b_pt_reg[k*CW +: CW]));
        end
        // stage 2: six cross terms
        q_reg[1] <= q_reg[0];
        m_reg[0] <= (2*D)'(da_reg[1]) * (2*D)'(db_reg[2]);
        m_reg[1] <= (2*D)'(da_reg[2]) * (2*D)'(db_reg[1]);
        m_reg[2] <= (2*D)'(da_reg[2]) * (2*D)'(db_reg[0]);
        m_reg[3] <= (2*D)'(da_reg[0]) * (2*D)'(db_reg[2]);
        m_reg[4] <= (2*D)'(da_reg[0]) * (2*D)'(db_reg[1]);
        m_reg[5] <= (2*D)'(da_reg[1]) * (2*D)'(db_reg[0]);
        // stage 3: component magnitudes
        q_reg[2] <= q_reg[1];
        for (int k = 0; k < 3; k++)
        begin
            if (m_reg[2*k] < m_reg[2*k+1])
            begin
                cmag_reg[k] <= (2*D)'((2*D+1)'(m_reg[2*k+1]) - (2*D+1)'(m_reg[2*k]));
            end
            else
            begin
                cmag_reg[k] <= (2*D)'((2*D+1)'(m_reg[2*k]) - (2*D+1)'(m_reg[2*k+1]));
            end
        end
        // stage 4: partial products of the squares
        q_reg[3] <= q_reg[2];
        for (int k = 0; k < 3; k++)
        begin
            hh_reg[k] <= (2*D)'(cmag_reg[k][2*D-1:D]) * (2*D)'(cmag_reg[k][2*D-1:D]);
            hl_reg[k] <= (2*D)'(cmag_reg[k][2*D-1:D]) * (2*D)'(cmag_reg[k][D-1:0]);
            ll_reg[k] <= (2*D)'(cmag_reg[k][D-1:0]) * (2*D)'(cmag_reg[k][D-1:0]);
        end
        // stage 5: assemble squares
        q_reg[4] <= q_reg[3];
        for (int k = 0; k < 3; k++)
        begin
            sq_reg[k] <= (SQW'(hh_reg[k]) << (2*D)) + (SQW'(hl_reg[k]) << (D+1))
                         + SQW'(ll_reg[k]);
        end
        // stage 6: sum
        q_reg[5] <= q_reg[4];
        sum_reg  <= SSW'(sq_reg[0]) + SSW'(sq_reg[1]) + SSW'(sq_reg[2]);
        // stage 7: keep the first strictly farthest point
        if (sv_reg[6] && s_better)
        begin
            cbest_d_reg <= sum_reg;
            c_pt_reg    <= q_reg[5];
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (job_pop && job_ctl.few)
        begin
            res_first_reg   <= '0;
            res_second_reg  <= '0;
            res_apex_reg    <= '0;
            res_outcome_reg <= hsf_pkg::OUTCOME_FEW;
        end
        else if (state_reg == S_FIN)
        begin
            res_first_reg   <= a_pt_reg;
            res_second_reg  <= b_pt_reg;
            res_apex_reg    <= c_pt_reg;
            res_outcome_reg <= ctl_reg.ovf ? hsf_pkg::OUTCOME_OVERFLOW : hsf_pkg::OUTCOME_OK;
        end
    end

    assign corners.valid    = (state_reg == S_OUT);
    assign corners.first_x  = 32'($signed(res_first_reg[0 +: CW]));
    assign corners.first_y  = 32'($signed(res_first_reg[CW +: CW]));
    assign corners.first_z  = 32'($signed(res_first_reg[2*CW +: CW]));
    assign corners.second_x = 32'($signed(res_second_reg[0 +: CW]));
    assign corners.second_y = 32'($signed(res_second_reg[CW +: CW]));
    assign corners.second_z = 32'($signed(res_second_reg[2*CW +: CW]));
    assign corners.apex_x   = 32'($signed(res_apex_reg[0 +: CW]));
    assign corners.apex_y   = 32'($signed(res_apex_reg[CW +: CW]));
    assign corners.apex_z   = 32'($signed(res_apex_reg[2*CW +: CW]));
    assign corners.outcome  = res_outcome_reg;

endmodule

// ===== rtl/hull_seed_triangle_3d.sv =====
`timescale 1ns / 1ps
// channel   dir  word
// points    in   pos_x, pos_y, pos_z, final_point
// corners   out  first_*, second_*, apex_*, outcome
//
// points load at one per cycle, unless loading stalls, into a two-bank point
// store; a set's last point hands its extremes to the back end through a
// two-entry job queue; back end per set: 15 pair tests, then a scan of n stored
// points through a pipeline that reads a new point before the last is through
// loading of the next set overlaps the scan; loading stalls with two sets pending
// reset clears control only, the point store needs no clearing pass
module hull_seed_triangle_3d #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    hsf_point_if.sink points,
    hsf_tri_if.source corners
);

    localparam int PW   = 3 * COORD_BITS;
    localparam int IDXW = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int EXW  = hsf_pkg::NUM_EXT * PW;
    localparam int CTW  = $bits(hsf_pkg::job_ctl_t);
    localparam int JW   = CTW + CNTW + EXW;

    logic                    room;
    logic                    wr_en;
    logic [IDXW:0]           wr_addr;
    logic [PW-1:0]           wr_data;
    logic                    rd_en;
    logic [IDXW:0]           rd_addr;
    logic [PW-1:0]           rd_data;
    logic                    job_push;
    hsf_pkg::job_ctl_t       push_ctl;
    logic [CNTW-1:0]         push_count;
    logic [EXW-1:0]          push_ext;
    logic                    job_valid;
    logic                    job_pop;
    logic [JW-1:0]           job_q;
    logic                    release_job;
    logic [1:0]              jobs_reg;

    // sets handed off and not yet delivered, one per store bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jobs_reg <= 2'd0;
        end
        else
        begin
            jobs_reg <= jobs_reg + {1'b0, job_push} - {1'b0, release_job};
        end
    end

    assign room = (jobs_reg != 2'd2);

    hsf_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (points),
        .room      (room),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_push  (job_push),
        .job_ctl   (push_ctl),
        .job_count (push_count),
        .job_ext   (push_ext)
    );

    hsf_job_fifo #(
        .WIDTH (JW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   ({push_ctl, push_count, push_ext}),
        .valid (job_valid),
        .pop   (job_pop),
        .dout  (job_q)
    );

    hsf_ram #(
        .WIDTH (PW),
        .DEPTH (2 << IDXW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hsf_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_ctl     (hsf_pkg::job_ctl_t'(job_q[JW-1 -: CTW])),
        .job_count   (job_q[EXW +: CNTW]),
        .job_ext     (job_q[EXW-1:0]),
        .job_pop     (job_pop),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .release_job (release_job),
        .corners     (corners)
    );

    // a set is never handed off while both banks are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (jobs_reg != 2'd2))
        else $error("set handed off with both banks busy");

    // a delivered word always belongs to an outstanding set
    assert property (@(posedge clk) disable iff (!rst_n)
        (corners.valid && corners.ready) |-> (jobs_reg != 2'd0))
        else $error("result delivered with no set outstanding");

    // the back end only takes a job while a set is outstanding
    assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (jobs_reg != 2'd0))
        else $error("job taken with no set outstanding");

endmodule

// ===== tb/hsf_tri_checker.sv =====
`timescale 1ns / 1ps
module hsf_tri_checker (
    input  logic clk,
    input  logic rst_n,
    hsf_point_if pts,
    hsf_tri_if   cor,
    output int   fails,
    output int   pending
);

    localparam int CAP = 1024;

    // one triangle word: nine coordinates then outcome
    typedef logic [9:0][31:0] tri_word_t;

    logic signed [31:0] pt_store [0:3*CAP-1];
    logic signed [31:0] ext_pt [0:hsf_pkg::NUM_EXT-1][0:2];
    int                 n_stored;
    logic               dropped;
    tri_word_t          tri_q [$];
    string              fld_name [10] = '{"first_x", "first_y", "first_z", "second_x",
                                          "second_y", "second_z", "apex_x", "apex_y",
                                          "apex_z", "outcome"};

    assign pending = tri_q.size();

    function automatic void clear_set();
        n_stored = 0;
        dropped  = 1'b0;
        for (int e = 0; e < hsf_pkg::NUM_EXT; e++)
        begin
            for (int k = 0; k < 3; k++)
                ext_pt[e][k] = 32'sd0;
        end
        for (int ax = 0; ax < 3; ax++)
        begin
            ext_pt[ax*2][ax]   = 32'sh7fffffff;
            ext_pt[ax*2+1][ax] = 32'sh80000000;
        end
    endfunction

    // squared distance between two extremes
    function automatic logic [159:0] ext_dist2(int i, int j);
        logic [159:0]       acc;
        logic signed [33:0] d;
        logic [33:0]        u;
        logic [159:0]       m;
        acc = '0;
        for (int k = 0; k < 3; k++)
        begin
            d = ext_pt[i][k] - ext_pt[j][k];
            u = d[33] ? -d : d;
            m = u;
            acc = acc + m * m;
        end
        return acc;
    endfunction

    // squared length of (p-a) x (p-b) for stored point n
    function automatic logic [159:0] line_dist2(int n, int ia, int ib);
        logic signed [33:0] a [3];
        logic signed [33:0] b [3];
        logic signed [71:0] c;
        logic [71:0]        u;
        logic [159:0]       m;
        logic [159:0]       acc;
        for (int k = 0; k < 3; k++)
        begin
            a[k] = pt_store[n*3+k] - ext_pt[ia][k];
            b[k] = pt_store[n*3+k] - ext_pt[ib][k];
        end
        acc = '0;
        for (int k = 0; k < 3; k++)
        begin
            c = a[(k+1)%3] * b[(k+2)%3] - a[(k+2)%3] * b[(k+1)%3];
            u = c[71] ? -c : c;
            m = u;
            acc = acc + m * m;
        end
        return acc;
    endfunction

    function automatic tri_word_t finish_set();
        tri_word_t    w;
        logic [159:0] best;
        logic [159:0] d;
        int           bi;
        int           bj;
        int           apex;
        w = '0;
        if (n_stored < hsf_pkg::MIN_POINTS)
        begin
            w[9] = hsf_pkg::OUTCOME_FEW;
        end
        else
        begin
            bi = 0;
            bj = 1;
            best = ext_dist2(0, 1);
            for (int i = 0; i < hsf_pkg::NUM_EXT; i++)
            begin
                for (int j = i + 1; j < hsf_pkg::NUM_EXT; j++)
                begin
                    d = ext_dist2(i, j);
                    if (d > best)
                    begin
                        best = d;
                        bi = i;
                        bj = j;
                    end
                end
            end
            apex = 0;
            best = line_dist2(0, bi, bj);
            for (int n = 1; n < n_stored; n++)
            begin
                d = line_dist2(n, bi, bj);
                if (d > best)
                begin
                    best = d;
                    apex = n;
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                w[k]   = ext_pt[bi][k];
                w[3+k] = ext_pt[bj][k];
                w[6+k] = pt_store[apex*3+k];
            end
            w[9] = dropped ? hsf_pkg::OUTCOME_OVERFLOW : hsf_pkg::OUTCOME_OK;
        end
        return w;
    endfunction

    // take accepted points into the model
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_set();
        end
        else if (pts.valid && pts.ready)
        begin
            logic signed [31:0] p [3];
            p[0] = pts.pos_x;
            p[1] = pts.pos_y;
            p[2] = pts.pos_z;
            if (n_stored < CAP)
            begin
                for (int k = 0; k < 3; k++)
                    pt_store[n_stored*3+k] = p[k];
                n_stored++;
                for (int ax = 0; ax < 3; ax++)
                begin
                    if (p[ax] < ext_pt[ax*2][ax])
                        for (int k = 0; k < 3; k++) ext_pt[ax*2][k] = p[k];
                    if (p[ax] > ext_pt[ax*2+1][ax])
                        for (int k = 0; k < 3; k++) ext_pt[ax*2+1][k] = p[k];
                end
            end
            else
            begin
                dropped = 1'b1;
            end
            if (pts.final_point)
            begin
                tri_q.push_back(finish_set());
                clear_set();
            end
        end
    end

    // compare each triangle word with the oldest prediction
    initial fails = 0;
    always @(posedge clk)
    begin
        if (rst_n && cor.valid && cor.ready)
        begin
            tri_word_t got;
            tri_word_t want;
            got = {30'd0, cor.outcome, cor.apex_z, cor.apex_y, cor.apex_x,
                   cor.second_z, cor.second_y, cor.second_x,
                   cor.first_z, cor.first_y, cor.first_x};
            if (tri_q.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected triangle word at %0t", $realtime);
            end
            else
            begin
                want = tri_q.pop_front();
                for (int f = 0; f < 10; f++)
                begin
                    if (got[f] !== want[f])
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch %s: expected %h got %h", fld_name[f],
                                     want[f], got[f]);
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic quiet = 1'b0;
    int   fails;
    int   pending;
    int   n_points = 0;
    int   n_sets = 0;
    int   n_big = 0;

    hsf_point_if pts ();
    hsf_tri_if   cor ();

    hull_seed_triangle_3d dut (.clk(clk), .rst_n(rst_n), .points(pts), .corners(cor));
    hsf_tri_checker chk (.clk(clk), .rst_n(rst_n), .pts(pts), .cor(cor),
                         .fails(fails), .pending(pending));

    always #6 clk = ~clk;

    initial
    begin
        pts.valid = 1'b0;
        pts.pos_x = '0;
        pts.pos_y = '0;
        pts.pos_z = '0;
        pts.final_point = 1'b0;
        cor.ready = 1'b0;
    end

    // receiver stalls
    always @(posedge clk)
        cor.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);

    task automatic send_word(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic f);
        if (!quiet)
        begin
            while ($urandom_range(99) < 22)
            begin
                pts.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pts.valid <= 1'b1;
        pts.pos_x <= x;
        pts.pos_y <= y;
        pts.pos_z <= z;
        pts.final_point <= f;
        @(posedge clk);
        while (!pts.ready)
            @(posedge clk);
        n_points++;
        if (f)
            n_sets++;
        quiet = (n_points >= 600 && n_points < 900);
    endtask

    function automatic logic [31:0] pick_coord(int mode);
        case ($urandom_range(9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            default:
                if (mode == 0)
                    return $urandom;
                else if (mode == 1)
                    return $urandom_range(16) - 8;
                else
                    return $urandom_range(32'h0003ffff) - 32'h00020000;
        endcase
    endfunction

    initial
    begin
        int sz;
        int mode;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone point, short set, corners of the range
        send_word(32'h7fffffff, 32'h80000000, 32'h00010000, 1'b1);
        send_word(32'h80000000, 32'h7fffffff, 32'h0, 1'b0);
        send_word(32'h0, 32'h0, 32'h80000000, 1'b0);
        send_word(32'h7fffffff, 32'h0, 32'h7fffffff, 1'b1);
        send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
        send_word(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
        send_word(32'h80000000, 32'h7fffffff, 32'h0, 1'b0);
        send_word(32'h0, 32'h0, 32'h7fffffff, 1'b1);
        // all points equal: degenerate line
        repeat (4) send_word(32'h00030000, 32'hfffd0000, 32'h1, 1'b0);
        send_word(32'h00030000, 32'hfffd0000, 32'h1, 1'b1);
        // x minimum never beaten
        for (int i = 0; i < 5; i++)
            send_word(32'h7fffffff, $urandom_range(100), $urandom_range(100), i == 4);

        // one set past capacity
        for (int i = 0; i < 1026; i++)
            send_word(pick_coord(2), pick_coord(2), pick_coord(2), i == 1025);
        n_big++;

        // random sets, mostly small
        while (n_points < 1700)
        begin
            case ($urandom_range(19))
                0, 1: sz = $urandom_range(3, 1);
                default: sz = $urandom_range(24, 4);
            endcase
            mode = $urandom_range(2);
            for (int i = 0; i < sz; i++)
                send_word(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == sz - 1);
        end
        pts.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("sent %0d points in %0d sets, %0d of them past capacity",
                 n_points, n_sets, n_big);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== hull_seed_triangle_3d.f =====
rtl/hsf_pkg.sv
rtl/hsf_point_if.sv
rtl/hsf_tri_if.sv
rtl/hsf_ram.sv
rtl/hsf_job_fifo.sv
rtl/hsf_front.sv
rtl/hsf_back.sv
rtl/hull_seed_triangle_3d.sv
tb/hsf_tri_checker.sv
tb/tb_top.sv
